// ===== sv/hmq_pkg.sv =====
// hmq_pkg: shared types and constants for the heightmap height query block
// no dependencies
`default_nettype none
package hmq_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SampW = 8;
  // samples per grid side held in the store
  localparam int unsigned MaxSide = 256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Z = 2'd1,
    CFG_VCOUNT = 2'd2,
    CFG_RECIP = 2'd3
  } cfg_idx_t;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // classified query passed from front to back
  typedef struct packed {
    logic in_grid;
    logic [7:0] gx;
    logic [7:0] gz;
    logic [7:0] fx;
    logic [7:0] fz;
  } query_t;
endpackage
`default_nettype wire

// ===== sv/heightmap_barycentric_height_query.sv =====
// Heightmap barycentric height query. Write items (mode 0) store one 8-bit
// sample and make no result; query items (mode 1) return one Q8.8 height and
// an in-range flag. One item is taken per cycle while results are taken; a
// four-entry result queue holds input back when it could overflow. A query
// passes through registered stages in order: the offset stage loads at the
// accepting edge, then come the scale (24x24 multiply), the grid read, the
// blend multiply and the queue write. Writes follow the same two front
// stages so they stay in order with queries. The grid is held in four parity
// banks so all corners of a cell read in the same cycle. Samples read before
// being written give undefined heights. Configuration must be written only
// while idle, by the user; the block itself does not enforce it.
`default_nettype none
module heightmap_barycentric_height_query (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic        mode,
  input  wire logic [7:0]  column,
  input  wire logic [7:0]  row,
  input  wire logic [7:0]  height_in,
  input  wire logic [23:0] world_x,
  input  wire logic [23:0] world_z,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [15:0] height_out,
  output      logic        in_range,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [23:0] cfg_data
);
  import hmq_pkg::*;

  logic [23:0] origin_x, origin_z, cell_recip;
  logic [8:0] side_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_z <= '0;
      side_count <= 9'd256; cell_recip <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Z: origin_z <= cfg_data;
        CFG_VCOUNT: side_count <= cfg_data[8:0];
        CFG_RECIP: cell_recip <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv, acc, fv, rv;
  query_t fq;
  assign full = !adv;
  assign acc = push && adv;

  // write path delayed to line up with the query read stage
  logic wr1_vld, wr2_vld;
  logic [7:0] wr1_col, wr1_row, wr1_data, wr2_col, wr2_row, wr2_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      wr1_vld <= 1'b0; wr2_vld <= 1'b0;
    end else if (adv) begin
      wr1_vld <= acc && mode == MODE_WRITE;
      wr2_vld <= wr1_vld;
    end
    if (adv) begin
      wr1_col <= column; wr1_row <= row; wr1_data <= height_in;
      wr2_col <= wr1_col; wr2_row <= wr1_row; wr2_data <= wr1_data;
    end
  end

  hmq_front u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(acc && mode == MODE_QUERY),
    .world_x(world_x), .world_z(world_z), .origin_x(origin_x), .origin_z(origin_z),
    .side_count(side_count), .cell_recip(cell_recip),
    .out_vld(fv), .out_q(fq)
  );

  hmq_back u_back (
    .clk(clk), .rst(rst),
    .wr_en(wr2_vld && adv), .wr_col(wr2_col), .wr_row(wr2_row), .wr_data(wr2_data),
    .q_vld(fv), .q(fq), .adv(adv), .res_vld(rv), .pop(pop),
    .height_out(height_out), .in_range(in_range)
  );

  assign empty = !rv;
endmodule
`default_nettype wire

// ===== sv/hmq_ram.sv =====
// hmq_ram: generic single-write, single-read RAM with registered read
// no dependencies
`default_nettype none
module hmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/hmq_front.sv =====
// hmq_front: offset, reciprocal scale and range check of a query (two stages)
// depends on hmq_pkg
`default_nettype none
module hmq_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_vld,
  input  wire logic [hmq_pkg::CoordW-1:0] world_x,
  input  wire logic [hmq_pkg::CoordW-1:0] world_z,
  input  wire logic [hmq_pkg::CoordW-1:0] origin_x,
  input  wire logic [hmq_pkg::CoordW-1:0] origin_z,
  input  wire logic [8:0]                 side_count,
  input  wire logic [hmq_pkg::CfgW-1:0]   cell_recip,
  output      logic                       out_vld,
  output      hmq_pkg::query_t            out_q
);
  import hmq_pkg::*;

  logic s1_vld, s1_neg;
  logic [CoordW-1:0] s1_dx, s1_dz;
  logic signed [CoordW:0] dx, dz;
  logic [47:0] tx, tz;
  logic [9:0] side, lim;
  logic [23:0] gxw, gzw;

  assign dx = $signed({world_x[CoordW-1], world_x}) - $signed({origin_x[CoordW-1], origin_x});
  assign dz = $signed({world_z[CoordW-1], world_z}) - $signed({origin_z[CoordW-1], origin_z});

  // stage 1: offset and sign check
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= in_vld;
    if (adv) begin
      s1_neg <= dx[CoordW] | dz[CoordW];
      s1_dx <= dx[CoordW-1:0];
      s1_dz <= dz[CoordW-1:0];
    end
  end

  assign tx = 48'(s1_dx) * 48'(cell_recip);
  assign tz = 48'(s1_dz) * 48'(cell_recip);
  assign gxw = tx[47:24];
  assign gzw = tz[47:24];
  assign side = (side_count > 9'(MaxSide)) ? 10'(MaxSide) : {1'b0, side_count};
  assign lim = side - 10'd1;

  // stage 2: scale to cell index and fraction, range check
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) out_vld <= s1_vld;
    if (adv) begin
      out_q.in_grid <= !s1_neg && (side >= 10'd2) && (gxw < 24'(lim)) && (gzw < 24'(lim));
      out_q.gx <= gxw[7:0];
      out_q.gz <= gzw[7:0];
      out_q.fx <= tx[23:16];
      out_q.fz <= tz[23:16];
    end
  end
endmodule
`default_nettype wire

// ===== sv/hmq_back.sv =====
// hmq_back: corner fetch from four banked grids, barycentric blend, result queue
// depends on hmq_pkg, hmq_ram
`default_nettype none
module hmq_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [7:0]               wr_col,
  input  wire logic [7:0]               wr_row,
  input  wire logic [hmq_pkg::SampW-1:0] wr_data,
  input  wire logic                     q_vld,
  input  wire hmq_pkg::query_t          q,
  output      logic                     adv,
  output      logic                     res_vld,
  input  wire logic                     pop,
  output      logic [15:0]              height_out,
  output      logic                     in_range
);
  import hmq_pkg::*;

  // four banks by column and row parity so all corners read in the same cycle
  logic [SampW-1:0] bank_q [4];
  logic [6:0] cx0, cx1, cz0, cz1;
  logic [7:0] gx1, gz1;
  assign gx1 = q.gx + 8'd1;
  assign gz1 = q.gz + 8'd1;
  assign cx0 = q.gx[0] ? gx1[7:1] : q.gx[7:1];
  assign cx1 = q.gx[0] ? q.gx[7:1] : gx1[7:1];
  assign cz0 = q.gz[0] ? gz1[7:1] : q.gz[7:1];
  assign cz1 = q.gz[0] ? q.gz[7:1] : gz1[7:1];

  // result queue of 4 entries with occupancy tracking of items in flight
  logic [16:0] fifo [4];
  logic [1:0] rp, wp;
  logic [2:0] cnt;
  logic [2:0] infl;
  logic p1_vld, p2_vld;

  assign adv = (cnt + infl) < 3'd4;
  assign infl = {2'b0, p1_vld} + {2'b0, p2_vld};

  generate
    for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic [1:0] Sel = 2'(b);
      hmq_ram #(.WIDTH(SampW), .DEPTH((MaxSide * MaxSide) / 4)) u_ram (
        .clk(clk),
        .we(wr_en && wr_col[0] == Sel[0] && wr_row[0] == Sel[1]),
        .waddr({wr_row[7:1], wr_col[7:1]}),
        .wdata(wr_data),
        .re(adv),
        .raddr({(Sel[1] ? cz1 : cz0), (Sel[0] ? cx1 : cx0)}),
        .rdata(bank_q[b])
      );
    end
  endgenerate

  // stage p1 aligned with ram read
  logic p1_in, p1_px, p1_pz;
  logic [7:0] p1_fx, p1_fz;
  always_ff @(posedge clk) begin
    if (rst) p1_vld <= 1'b0;
    else if (adv) p1_vld <= q_vld;
    else p1_vld <= 1'b0;
    if (adv) begin
      p1_in <= q.in_grid;
      p1_px <= q.gx[0];
      p1_pz <= q.gz[0];
      p1_fx <= q.fx;
      p1_fz <= q.fz;
    end
  end

  // corner unscramble and triangle weights
  logic [7:0] h00, h10, h01, h11;
  logic [8:0] fsum;
  logic lower;
  logic [8:0] wa, wb, wc;
  logic [7:0] ha, hb, hc;
  always_comb begin
    h00 = bank_q[{p1_pz, p1_px}];
    h10 = bank_q[{p1_pz, ~p1_px}];
    h01 = bank_q[{~p1_pz, p1_px}];
    h11 = bank_q[{~p1_pz, ~p1_px}];
    fsum = {1'b0, p1_fx} + {1'b0, p1_fz};
    lower = fsum <= 9'd256;
    if (lower) begin
      ha = h00; wa = 9'd256 - fsum;
      hb = h10; wb = {1'b0, p1_fx};
      hc = h01; wc = {1'b0, p1_fz};
    end else begin
      ha = h10; wa = 9'd256 - {1'b0, p1_fz};
      hb = h11; wb = fsum - 9'd256;
      hc = h01; wc = 9'd256 - {1'b0, p1_fx};
    end
  end

  // stage p2: three small products
  logic [16:0] pa, pb, pc;
  logic p2_in;
  always_ff @(posedge clk) begin
    if (rst) p2_vld <= 1'b0;
    else p2_vld <= p1_vld;
    pa <= 17'(ha) * 17'(wa);
    pb <= 17'(hb) * 17'(wb);
    pc <= 17'(hc) * 17'(wc);
    p2_in <= p1_in;
  end

  logic [16:0] hsum;
  assign hsum = pa + pb + pc;
  logic do_pop;
  assign do_pop = pop && res_vld;

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0; wp <= '0; cnt <= '0;
    end else begin
      if (p2_vld) wp <= wp + 2'd1;
      if (do_pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, p2_vld} - {2'b0, do_pop};
    end
    if (p2_vld) fifo[wp] <= {p2_in, (p2_in ? hsum[15:0] : 16'd0)};
  end

  assign res_vld = cnt != 3'd0;
  assign {in_range, height_out} = fifo[rp];

  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt + infl) <= 3'd4)
    else $error("credit overrun");
  assert property (@(posedge clk) disable iff (rst) p1_vld |=> p2_vld)
    else $error("lost item in blend");
endmodule
`default_nettype wire
